>>> rtl/cfbn_pkg.sv
package cfbn_pkg;

    localparam int CoordW = 20;
    localparam int FieldW = 16;
    localparam int EntryW = 2 * CoordW + 2 * CoordW + FieldW;
    localparam logic [CoordW-1:0] Sat20 = 20'hFFFFF;

    localparam logic [1:0] RegConf  = 2'd0;
    localparam logic [1:0] RegIou   = 2'd1;
    localparam logic [1:0] RegScaleX = 2'd2;
    localparam logic [1:0] RegScaleY = 2'd3;

    typedef struct packed {
        logic [FieldW-1:0] center_x;
        logic [FieldW-1:0] center_y;
        logic [FieldW-1:0] box_width;
        logic [FieldW-1:0] box_height;
        logic [FieldW-1:0] score;
        logic              last_prediction;
    } box_in_t;

    typedef struct packed {
        logic [CoordW-1:0] kept_x;
        logic [CoordW-1:0] kept_y;
        logic [CoordW-1:0] kept_width;
        logic [CoordW-1:0] kept_height;
        logic [FieldW-1:0] kept_score;
        logic [6:0]        survivor_total;
        logic              none_found;
        logic              overflowed;
        logic              last_result;
    } box_out_t;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
        logic [FieldW-1:0] score;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_NMS_RD,
        ST_NMS_CMP,
        ST_NMS_WAIT,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT,
        ST_EMPTY
    } state_t;

    // A 16x16 product shifted down by 12 always fits in 20 bits, so no
    // clamp to Sat20 is applied.
    function automatic logic [CoordW-1:0] scale_sat(input logic [FieldW-1:0] v,
                                                     input logic [FieldW-1:0] s);
        logic [31:0] p;
        begin
            p = v * s;
            scale_sat = p[31:12];
        end
    endfunction

endpackage

>>> rtl/cfbn_if.sv
interface cfbn_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cfbn_iou.sv
module cfbn_iou
    import cfbn_pkg::*;
(
    input  logic                clk,
    input  entry_t              a,
    input  entry_t              b,
    input  logic [FieldW-1:0]   iou_threshold,
    output logic                hit
);
    // Stage 1: clipped doubled-corner intersection extents and areas.
    logic signed [22:0] al, ar, bl, br, at, ad, bt, bd, l, r, t, d;
    logic [21:0] iw_next, ih_next, iw_reg, ih_reg;
    logic [39:0] aa_next, ab_next, aa_reg, ab_reg;
    logic [43:0] inter_reg;
    logic [42:0] uni;
    logic [61:0] lhs, rhs;

    always_comb
    begin
        al = $signed({2'b0, a.x, 1'b0}) - $signed({3'b0, a.w});
        ar = $signed({2'b0, a.x, 1'b0}) + $signed({3'b0, a.w});
        bl = $signed({2'b0, b.x, 1'b0}) - $signed({3'b0, b.w});
        br = $signed({2'b0, b.x, 1'b0}) + $signed({3'b0, b.w});
        at = $signed({2'b0, a.y, 1'b0}) - $signed({3'b0, a.h});
        ad = $signed({2'b0, a.y, 1'b0}) + $signed({3'b0, a.h});
        bt = $signed({2'b0, b.y, 1'b0}) - $signed({3'b0, b.h});
        bd = $signed({2'b0, b.y, 1'b0}) + $signed({3'b0, b.h});
        l = (al > bl) ? al : bl;
        r = (ar < br) ? ar : br;
        t = (at > bt) ? at : bt;
        d = (ad < bd) ? ad : bd;
        iw_next = (r > l) ? 22'(r - l) : '0;
        ih_next = (d > t) ? 22'(d - t) : '0;
        aa_next = a.w * a.h;
        ab_next = b.w * b.h;
    end

    always_ff @(posedge clk)
    begin
        iw_reg <= iw_next;
        ih_reg <= ih_next;
        aa_reg <= aa_next;
        ab_reg <= ab_next;
        inter_reg <= iw_reg * ih_reg;
    end

    // Stage 3: compare inter*65536 against threshold*union.
    logic [39:0] aa_d, ab_d;
    always_ff @(posedge clk)
    begin
        aa_d <= aa_reg;
        ab_d <= ab_reg;
    end

    always_comb
    begin
        uni = {1'b0, aa_d, 2'b0} + {1'b0, ab_d, 2'b0} - 43'(inter_reg);
        lhs = {2'b0, inter_reg, 16'b0};
        rhs = 62'(uni) * 62'(iou_threshold);
    end

    always_ff @(posedge clk)
        hit <= lhs > rhs;
endmodule

>>> rtl/cfbn_store.sv
module cfbn_store
    import cfbn_pkg::*;
#(
    parameter int Depth = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  entry_t                   wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output entry_t                   rdata
);
    entry_t mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/confidence_filter_box_nms_unit.sv
// Confidence filter with greedy overlap suppression.
// Input channel in_box: one box prediction per item. Boxes with a score at
// or above the RegConf threshold (conf_reg) are scaled and put in a score-ordered store of
// MAX_CANDIDATES entries (ties keep arrival order; a full store drops the
// lowest entry and raises the overflow flag).
// An item marked last_prediction starts suppression: each pair (i,j), i<j, whose
// anchor i is not suppressed goes through the memory read and the 3-stage overlap unit.
// Output channel out_box: one item per survivor in store order, or one item
// with none_found set when nothing survived; last_result marks the last.
// Insertion reads each entry scanned and each entry shifted through the
// single store read port.
// The block takes one item at a time; in_box.ready is low while busy.
// A stalled receiver holds the output item and stalls the sequencer before it builds another.
// Reset clears the count, overflow flag, suppression marks and registers
// to their defaults; store contents are not cleared and need no pass.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply at once.
module confidence_filter_box_nms_unit
    import cfbn_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    cfbn_if.sink        in_box,
    cfbn_if.source      out_box
);
    localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam logic [CW-1:0] CountMax = CW'(MAX_CANDIDATES);

    logic [15:0] conf_reg, iou_reg, sx_reg, sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_reg <= 16'd32768;
            iou_reg  <= 16'd29491;
            sx_reg   <= 16'd4096;
            sy_reg   <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegConf:   conf_reg <= cfg_data;
                RegIou:    iou_reg  <= cfg_data;
                RegScaleX: sx_reg   <= cfg_data;
                RegScaleY: sy_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic last_reg, last_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, p_reg, p_next;
    logic [CW-1:0] k_reg, k_next;
    logic [6:0] surv_reg, surv_next, nout_reg, nout_next;
    logic [MAX_CANDIDATES-1:0] sup_reg, sup_next;
    logic [2:0] wait_reg, wait_next;
    box_in_t in_reg;
    entry_t new_reg, ent_a_reg, hold_reg;
    box_out_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata, rdata;
    logic hit;

    cfbn_store #(.Depth(MAX_CANDIDATES)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    cfbn_iou u_iou (
        .clk(clk), .a(ent_a_reg), .b(rdata), .iou_threshold(iou_reg), .hit(hit)
    );

    always_ff @(posedge clk)
    begin
        if (in_box.valid && in_box.ready)
            in_reg <= in_box.data;
        if (state_reg == ST_SCALE)
        begin
            new_reg.x <= scale_sat(in_reg.center_x, sx_reg);
            new_reg.y <= scale_sat(in_reg.center_y, sy_reg);
            new_reg.w <= scale_sat(in_reg.box_width, sx_reg);
            new_reg.h <= scale_sat(in_reg.box_height, sy_reg);
            new_reg.score <= in_reg.score;
        end
        // The anchor read issued in ST_NMS_RD lands during ST_NMS_WAIT.
        if (state_reg == ST_NMS_WAIT)
            ent_a_reg <= rdata;
        if (state_reg == ST_SHIFT_RD || state_reg == ST_OUT_WAIT)
            hold_reg <= rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            last_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            p_reg <= '0;
            k_reg <= '0;
            surv_reg <= '0;
            nout_reg <= '0;
            sup_reg <= '0;
            wait_reg <= '0;
            ovalid_reg <= 1'b0;
            obuf_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            last_reg <= last_next;
            i_reg <= i_next;
            j_reg <= j_next;
            p_reg <= p_next;
            k_reg <= k_next;
            surv_reg <= surv_next;
            nout_reg <= nout_next;
            sup_reg <= sup_next;
            wait_reg <= wait_next;
            ovalid_reg <= ovalid_next;
            obuf_reg <= obuf_next;
        end
    end

    assign in_box.ready = (state_reg == ST_IDLE);
    assign out_box.valid = ovalid_reg;
    assign out_box.data = obuf_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        last_next = last_reg;
        i_next = i_reg;
        j_next = j_reg;
        p_next = p_reg;
        k_next = k_reg;
        surv_next = surv_reg;
        nout_next = nout_reg;
        sup_next = sup_reg;
        wait_next = wait_reg;
        obuf_next = obuf_reg;
        ovalid_next = ovalid_reg && !out_box.ready;
        we = 1'b0;
        waddr = AW'(k_reg);
        wdata = hold_reg;
        raddr = AW'(p_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_box.valid)
                begin
                    last_next = in_box.data.last_prediction;
                    p_next = '0;
                    if (in_box.data.score >= conf_reg)
                        state_next = ST_SCALE;
                    else if (in_box.data.last_prediction)
                    begin
                        i_next = '0;
                        surv_next = '0;
                        nout_next = '0;
                        state_next = ST_NMS_RD;
                        j_next = '0;
                    end
                end
            end
            ST_SCALE:
                state_next = ST_SCAN_RD;
            // Find the insert point: first entry whose score is below the new one.
            ST_SCAN_RD:
            begin
                if (p_reg >= count_reg)
                    state_next = ST_SCAN;
                else
                begin
                    raddr = AW'(p_reg);
                    state_next = ST_SCAN;
                    wait_next = 3'd1;
                end
            end
            ST_SCAN:
            begin
                if (p_reg < count_reg && wait_reg != 3'd0 && rdata.score >= new_reg.score)
                begin
                    p_next = p_reg + 1'b1;
                    wait_next = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    wait_next = '0;
                    if (count_reg >= CountMax)
                    begin
                        ovf_next = 1'b1;
                        k_next = CountMax - 1'b1;
                    end
                    else
                    begin
                        k_next = count_reg;
                        count_next = count_reg + 1'b1;
                    end
                    if (count_reg >= CountMax && p_reg >= CountMax)
                        state_next = ST_NMS_RD;
                    else
                        state_next = ST_SHIFT_RD;
                    if (count_reg >= CountMax && p_reg >= CountMax && !last_reg)
                        state_next = ST_IDLE;
                    i_next = '0;
                    j_next = '0;
                    surv_next = '0;
                    nout_next = '0;
                end
            end
            // Move entries up one place from the tail down to the insert point.
            ST_SHIFT_RD:
            begin
                if (k_reg > p_reg)
                begin
                    raddr = AW'(k_reg - 1'b1);
                    state_next = ST_SHIFT_WR;
                end
                else
                    state_next = ST_PUT;
            end
            ST_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = AW'(k_reg);
                wdata = rdata;
                k_next = k_reg - 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_PUT:
            begin
                we = 1'b1;
                waddr = AW'(p_reg);
                wdata = new_reg;
                state_next = last_reg ? ST_NMS_RD : ST_IDLE;
            end
            // Greedy suppression: j==i loads the anchor, j>i compares.
            ST_NMS_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next = '0;
                    nout_next = '0;
                    state_next = (surv_reg == '0) ? ST_EMPTY : ST_OUT_RD;
                end
                else if (j_reg == i_reg)
                begin
                    raddr = AW'(i_reg);
                    if (sup_reg[AW'(i_reg)])
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + 1'b1;
                        state_next = ST_NMS_RD;
                    end
                    else
                    begin
                        surv_next = surv_reg + 1'b1;
                        state_next = ST_NMS_WAIT;
                        wait_next = '0;
                    end
                end
                else if (j_reg >= count_reg)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = i_reg + 1'b1;
                end
                else
                begin
                    raddr = AW'(j_reg);
                    state_next = ST_NMS_CMP;
                    wait_next = '0;
                end
            end
            ST_NMS_WAIT:
            begin
                j_next = i_reg + 1'b1;
                state_next = ST_NMS_RD;
            end
            ST_NMS_CMP:
            begin
                raddr = AW'(j_reg);
                wait_next = wait_reg + 1'b1;
                if (wait_reg == 3'd3)
                begin
                    if (hit)
                        sup_next[AW'(j_reg)] = 1'b1;
                    j_next = j_reg + 1'b1;
                    state_next = ST_NMS_RD;
                end
            end
            ST_OUT_RD:
            begin
                if (!ovalid_next)
                begin
                    if (i_reg >= count_reg)
                    begin
                        count_next = '0;
                        ovf_next = 1'b0;
                        sup_next = '0;
                        state_next = ST_IDLE;
                    end
                    else if (sup_reg[AW'(i_reg)])
                        i_next = i_reg + 1'b1;
                    else
                    begin
                        raddr = AW'(i_reg);
                        state_next = ST_OUT_WAIT;
                    end
                end
            end
            ST_OUT_WAIT:
                state_next = ST_OUT;
            ST_OUT:
            begin
                obuf_next.kept_x = hold_reg.x;
                obuf_next.kept_y = hold_reg.y;
                obuf_next.kept_width = hold_reg.w;
                obuf_next.kept_height = hold_reg.h;
                obuf_next.kept_score = hold_reg.score;
                obuf_next.survivor_total = surv_reg;
                obuf_next.none_found = 1'b0;
                obuf_next.overflowed = ovf_reg;
                obuf_next.last_result = (nout_reg + 1'b1 == surv_reg);
                ovalid_next = 1'b1;
                nout_next = nout_reg + 1'b1;
                i_next = i_reg + 1'b1;
                state_next = ST_OUT_RD;
            end
            ST_EMPTY:
            begin
                if (!ovalid_next)
                begin
                    obuf_next = '0;
                    obuf_next.none_found = 1'b1;
                    obuf_next.overflowed = ovf_reg;
                    obuf_next.last_result = 1'b1;
                    ovalid_next = 1'b1;
                    count_next = '0;
                    ovf_next = 1'b0;
                    sup_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountMax) else $error("candidate count above store depth");
    a_idle_no_marks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> sup_reg == '0) else $error("marks left after frame");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_box.valid && !out_box.ready |=> out_box.valid) else $error("output item lost");
    a_surv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nout_reg <= surv_reg) else $error("more results than survivors");
endmodule
